/* rtl/bst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// shared widths, constants, codes and entry type of the beacon signal table
// ----------------------------------------------------------------------------
package bst_pkg;

	localparam int unsigned DEF_TABLE_DEPTH = 16;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned SAMPLE_W   = 8;
	localparam int unsigned SIG_W      = 18;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned SLOT_OUT_W = 4;
	localparam int unsigned SCALED_W   = 15;
	localparam int unsigned SUM_W      = SIG_W + 1;
	localparam int unsigned BLEND_W    = SIG_W + 4;
	localparam int unsigned CEIL_W     = 14;

	// sample scaling and averaging
	localparam logic [SCALED_W-1:0] SCALE      = SCALED_W'(100);
	localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(10);
	localparam logic [CNT_W-1:0]    COUNT_MAX  = CNT_W'(15);
	localparam logic [CEIL_W-1:0]   SIG_CEIL   = CEIL_W'(10000);

	// divide by ten as multiply by ceil(2^22 / 10), exact for sums below 2^19
	localparam int unsigned DIV10_SHIFT = 22;
	localparam int unsigned DIV10_MUL_W = 19;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(419431);
	localparam int unsigned PROD_W = SUM_W + DIV10_MUL_W;

	// update status codes
	localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [SIG_W-1:0]  sig;
		logic [CNT_W-1:0]  cnt;
		logic              more_data;
		logic              eligible;
	} entry_t;

endpackage

/* rtl/bst_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_in_if
// beacon channel: valid/ready handshake with the beacon word
// ----------------------------------------------------------------------------
interface bst_in_if;
	logic                        valid;
	logic                        ready;
	logic [bst_pkg::ADDR_W-1:0]   ap_address;
	logic [bst_pkg::SAMPLE_W-1:0] signal_sample;
	logic                        more_data;

	modport source (output valid, ap_address, signal_sample, more_data, input ready);
	modport sink   (input valid, ap_address, signal_sample, more_data, output ready);
	modport mon    (input valid, ready, ap_address, signal_sample, more_data);
endinterface

/* rtl/bst_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_out_if
// result channel: valid/ready handshake with the table update word
// ----------------------------------------------------------------------------
interface bst_out_if;
	logic                          valid;
	logic                          ready;
	logic [bst_pkg::STATUS_W-1:0]   update_status;
	logic [bst_pkg::SLOT_OUT_W-1:0] entry_slot;
	logic                          rider_found;
	logic [bst_pkg::SLOT_OUT_W-1:0] rider_slot;
	logic [bst_pkg::ADDR_W-1:0]     rider_address;

	modport source (output valid, update_status, entry_slot, rider_found, rider_slot,
		rider_address, input ready);
	modport sink   (input valid, update_status, entry_slot, rider_found, rider_slot,
		rider_address, output ready);
	modport mon    (input valid, ready, update_status, entry_slot, rider_found, rider_slot,
		rider_address);
endinterface

/* rtl/bst_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_cell
// one table entry of the rotating ring; loads its neighbor's entry on shift
// ----------------------------------------------------------------------------
module bst_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  bst_pkg::entry_t d,
	output bst_pkg::entry_t q
);
	import bst_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [SIG_W-1:0]  sig_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              md_q;
	logic              elig_q;

	// address has no reset, only entries below the fill count are looked at
	always_ff @(posedge clk) begin
		if (shift_en) begin
			addr_q <= d.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q  <= '0;
			cnt_q  <= '0;
			md_q   <= 1'b0;
			elig_q <= 1'b0;
		end else if (shift_en) begin
			sig_q  <= d.sig;
			cnt_q  <= d.cnt;
			md_q   <= d.more_data;
			elig_q <= d.eligible;
		end
	end

	assign q = '{addr: addr_q, sig: sig_q, cnt: cnt_q, more_data: md_q, eligible: elig_q};

endmodule

/* rtl/bst_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_update
// signal arithmetic at the ring head: accumulate, divide by ten, or blend
// ----------------------------------------------------------------------------
module bst_update (
	input  logic                          clk,
	input  logic [bst_pkg::ADDR_W-1:0]    key_addr,
	input  logic [bst_pkg::SAMPLE_W-1:0]  key_sample,
	input  logic                          key_md,
	input  logic [bst_pkg::SIG_W-1:0]     prev_sig,
	input  logic [bst_pkg::CNT_W-1:0]     prev_cnt,
	output bst_pkg::entry_t               fresh,
	output bst_pkg::entry_t               upd_s2
);
	import bst_pkg::*;

	logic [SCALED_W-1:0] scaled;
	logic [SUM_W-1:0]    sum;
	logic [BLEND_W-1:0]  blend;
	logic [CNT_W-1:0]    cnt_new;

	logic [PROD_W-1:0]   prod_s1;
	logic [SUM_W-1:0]    sum_s1;
	logic [SIG_W-1:0]    blend_s1;
	logic [CNT_W-1:0]    cnt_s1;
	logic                use_sum_s1;
	logic [SIG_W-1:0]    sig_sel;

	assign scaled = SCALED_W'({{(SCALED_W-SAMPLE_W){1'b0}}, key_sample} * SCALE);
	assign sum    = SUM_W'(prev_sig) + SUM_W'(scaled);
	// 875:125 per thousand is exactly (7 * old + new) / 8
	assign blend  = (BLEND_W'(prev_sig) << 3) - BLEND_W'(prev_sig) + BLEND_W'(scaled);
	assign cnt_new = (prev_cnt != COUNT_MAX) ? prev_cnt + CNT_W'(1) : prev_cnt;

	assign fresh = '{addr: key_addr, sig: SIG_W'(scaled), cnt: CNT_W'(1),
		more_data: key_md, eligible: 1'b0};

	always_ff @(posedge clk) begin
		prod_s1    <= PROD_W'(sum) * PROD_W'(DIV10_MUL);
		sum_s1     <= sum;
		blend_s1   <= blend[SIG_W+2:3];
		cnt_s1     <= cnt_new;
		use_sum_s1 <= (prev_cnt < FULL_COUNT);
	end

	always_comb begin
		if (cnt_s1 == FULL_COUNT) begin
			sig_sel = prod_s1[DIV10_SHIFT+SIG_W-1:DIV10_SHIFT];
		end else if (use_sum_s1) begin
			sig_sel = sum_s1[SIG_W-1:0];
		end else begin
			sig_sel = blend_s1;
		end
	end

	always_ff @(posedge clk) begin
		upd_s2 <= '{addr: key_addr, sig: sig_sel, cnt: cnt_s1, more_data: key_md,
			eligible: key_md && (cnt_s1 > FULL_COUNT)};
	end

endmodule

/* rtl/beacon_signal_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_signal_table
// per-sender signal table with averaging and rider selection
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | word
//  beacon  | in  | valid/ready  | ap_address, signal_sample, more_data
//  result  | out | valid/ready  | update_status, entry_slot, rider_found,
//          |     |              | rider_slot, rider_address
//
// one beacon takes a full turn of the entry ring to find the address, the
// signal arithmetic in S_CALC1 and S_CALC2, and a second full turn to write
// the entry back and pick the rider
// the result sits in an output register; the next beacon is taken while it
// waits, and the block only holds in S_DONE while the register stays full
// reset clears every entry's signal, count and flags and the fill count at once
// ----------------------------------------------------------------------------
module beacon_signal_table #(
	parameter int unsigned TABLE_DEPTH = bst_pkg::DEF_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	bst_in_if.sink       beacon,
	bst_out_if.source    result
);
	import bst_pkg::*;

	localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EXT_W  = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
	localparam logic [USED_W-1:0] FULL_USED = USED_W'(TABLE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_CALC1 = 6'b000100,
		S_CALC2 = 6'b001000,
		S_SWEEP = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// beacon word held for the whole item
	logic [ADDR_W-1:0]   key_addr_q;
	logic [SAMPLE_W-1:0] key_sample_q;
	logic                key_md_q;

	// ring position and fill count
	logic [SLOT_W-1:0] k_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] k_ext;

	// lookup result
	logic              hit_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SIG_W-1:0]  hit_sig_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;

	// running minimum over the second turn
	logic              best_found_q;
	logic [CEIL_W-1:0] best_sig_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [ADDR_W-1:0] best_addr_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_found_q;
	logic [SLOT_W-1:0]   out_rslot_q;
	logic [ADDR_W-1:0]   out_raddr_q;
	logic [EXT_W-1:0]    out_slot_ext;
	logic [EXT_W-1:0]    out_rslot_ext;

	entry_t cell_in  [TABLE_DEPTH];
	entry_t cell_out [TABLE_DEPTH];
	entry_t head_next;
	entry_t fresh;
	entry_t upd_s2;

	logic shift_en;
	logic in_use;
	logic add_new;
	logic cand_valid;
	logic head_match;
	logic out_load;

	assign k_ext    = USED_W'(k_q);
	assign in_use   = (k_ext < used_q);
	assign shift_en = (state_q == S_SCAN) || (state_q == S_SWEEP);
	assign add_new  = !hit_q && (used_q != FULL_USED);

	// ring of entries: every cell takes its upper neighbor, the top cell
	// takes the head, possibly rewritten, so one turn brings all slots home
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
		if (i == TABLE_DEPTH - 1) begin : g_top
			assign cell_in[i] = head_next;
		end else begin : g_mid
			assign cell_in[i] = cell_out[i+1];
		end
		bst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (cell_in[i]),
			.q        (cell_out[i])
		);
	end

	bst_update u_update (
		.clk        (clk),
		.key_addr   (key_addr_q),
		.key_sample (key_sample_q),
		.key_md     (key_md_q),
		.prev_sig   (hit_sig_q),
		.prev_cnt   (hit_cnt_q),
		.fresh      (fresh),
		.upd_s2     (upd_s2)
	);

	// head rewrite on the second turn: matched slot gets the update,
	// the first free slot gets a new entry
	always_comb begin
		head_next = cell_out[0];
		if (state_q == S_SWEEP) begin
			if (hit_q && (k_q == hit_slot_q)) begin
				head_next = upd_s2;
			end else if (add_new && (k_ext == used_q)) begin
				head_next = fresh;
			end
		end
	end

	assign head_match = (state_q == S_SCAN) && in_use && !hit_q &&
		(cell_out[0].addr == key_addr_q);
	// a slot counts for the minimum if it is in use after this update
	assign cand_valid = in_use || (add_new && (k_ext == used_q));
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || result.ready);

	assign beacon.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			used_q       <= '0;
			hit_q        <= 1'b0;
			best_found_q <= 1'b0;
			best_sig_q   <= SIG_CEIL;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (beacon.valid) begin
						state_q      <= S_SCAN;
						k_q          <= '0;
						hit_q        <= 1'b0;
						best_found_q <= 1'b0;
						best_sig_q   <= SIG_CEIL;
					end
				end
				S_SCAN: begin
					if (head_match) begin
						hit_q <= 1'b1;
					end
					if (k_q == LAST_SLOT) begin
						k_q     <= '0;
						state_q <= S_CALC1;
					end else begin
						k_q <= k_q + SLOT_W'(1);
					end
				end
				S_CALC1: begin
					state_q <= S_CALC2;
				end
				S_CALC2: begin
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (cand_valid && head_next.eligible &&
						(head_next.sig < SIG_W'(best_sig_q))) begin
						best_found_q <= 1'b1;
						best_sig_q   <= head_next.sig[CEIL_W-1:0];
					end
					if (k_q == LAST_SLOT) begin
						k_q     <= '0;
						state_q <= S_DONE;
						if (add_new) begin
							used_q <= used_q + USED_W'(1);
						end
					end else begin
						k_q <= k_q + SLOT_W'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// beacon word, lookup capture and rider payload
	always_ff @(posedge clk) begin
		if (beacon.valid && beacon.ready) begin
			key_addr_q   <= beacon.ap_address;
			key_sample_q <= beacon.signal_sample;
			key_md_q     <= beacon.more_data;
		end
		if (head_match) begin
			hit_slot_q <= k_q;
			hit_sig_q  <= cell_out[0].sig;
			hit_cnt_q  <= cell_out[0].cnt;
		end
		if (state_q == S_CALC1) begin
			if (hit_q) begin
				status_q <= ST_UPDATED;
				slot_q   <= hit_slot_q;
			end else if (used_q == FULL_USED) begin
				status_q <= ST_DROPPED;
				slot_q   <= '0;
			end else begin
				status_q <= ST_ADDED;
				slot_q   <= SLOT_W'(used_q);
			end
		end
		if ((state_q == S_SWEEP) && cand_valid && head_next.eligible &&
			(head_next.sig < SIG_W'(best_sig_q))) begin
			best_slot_q <= k_q;
			best_addr_q <= head_next.addr;
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_slot_q   <= slot_q;
			out_found_q  <= best_found_q;
			out_rslot_q  <= best_found_q ? best_slot_q : '0;
			out_raddr_q  <= best_found_q ? best_addr_q : '0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// slots are reported in their low four bits
	assign out_slot_ext  = EXT_W'(out_slot_q);
	assign out_rslot_ext = EXT_W'(out_rslot_q);

	assign result.valid         = out_valid_q;
	assign result.update_status = out_status_q;
	assign result.entry_slot    = out_slot_ext[SLOT_OUT_W-1:0];
	assign result.rider_found   = out_found_q;
	assign result.rider_slot    = out_rslot_ext[SLOT_OUT_W-1:0];
	assign result.rider_address = out_raddr_q;

endmodule

/* rtl/bst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_checker
// port-level checks on the beacon signal table, bound to the top level
// ----------------------------------------------------------------------------
module bst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          beacon_valid,
	input logic                          beacon_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [bst_pkg::STATUS_W-1:0]   update_status,
	input logic [bst_pkg::SLOT_OUT_W-1:0] entry_slot,
	input logic                          rider_found,
	input logic [bst_pkg::SLOT_OUT_W-1:0] rider_slot,
	input logic [bst_pkg::ADDR_W-1:0]     rider_address
);
	import bst_pkg::*;

	// a stalled result word holds
	property p_result_hold;
		@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
			(result_valid && $stable(update_status) && $stable(entry_slot) &&
			 $stable(rider_found) && $stable(rider_slot) &&
			 $stable(rider_address));
	endproperty
	a_result_hold: assert property (p_result_hold) else $error("result word changed in stall");

	// one beacon at a time: busy right after taking one
	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n)
		(beacon_valid && beacon_ready) |=> !beacon_ready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("beacon taken while previous one in work");

	// a dropped beacon reports slot zero
	property p_drop_slot;
		@(posedge clk) disable iff (!arst_n)
		(result_valid && (update_status == ST_DROPPED)) |-> (entry_slot == '0);
	endproperty
	a_drop_slot: assert property (p_drop_slot) else $error("dropped beacon with nonzero slot");

	// no rider means zero rider fields
	property p_no_rider;
		@(posedge clk) disable iff (!arst_n)
		(result_valid && !rider_found) |->
			((rider_slot == '0) && (rider_address == '0));
	endproperty
	a_no_rider: assert property (p_no_rider) else $error("rider fields set without rider");

endmodule

bind beacon_signal_table bst_checker u_bst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.beacon_valid  (beacon.valid),
	.beacon_ready  (beacon.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.update_status (result.update_status),
	.entry_slot    (result.entry_slot),
	.rider_found   (result.rider_found),
	.rider_slot    (result.rider_slot),
	.rider_address (result.rider_address)
);

/* bench/beacon_signal_table_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_signal_table_check
// watches the beacon and result channels, keeps its own copy of the signal
// table, predicts each table update word and compares it with the block
// ----------------------------------------------------------------------------
module beacon_signal_table_check #(
	parameter int unsigned TABLE_DEPTH = bst_pkg::DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	bst_in_if.mon       beacon,
	bst_out_if.mon      result,
	output int unsigned bad_words,
	output int unsigned words_pending
);
	import bst_pkg::*;

	localparam int unsigned BLEND_KEEP   = 875;
	localparam int unsigned BLEND_NEW    = 125;
	localparam int unsigned BLEND_TOTAL  = 1000;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  found;
		logic [SLOT_OUT_W-1:0] rider_slot;
		logic [ADDR_W-1:0]     rider_addr;
	} table_update_t;

	logic [ADDR_W-1:0] tab_addr [TABLE_DEPTH];
	logic [SIG_W-1:0]  tab_sig  [TABLE_DEPTH];
	logic [CNT_W-1:0]  tab_cnt  [TABLE_DEPTH];
	logic              tab_md   [TABLE_DEPTH];
	logic              tab_elig [TABLE_DEPTH];
	int unsigned       tab_used;

	table_update_t pending_updates [$];

	// applies one beacon to the table copy and returns the update word it causes
	function automatic table_update_t predict_update(logic [ADDR_W-1:0] addr,
			logic [SAMPLE_W-1:0] sample, logic md);
		table_update_t u;
		int hit;
		int best;
		int unsigned s, prev, cnt, sig, scaled, best_sig;
		u = '0;
		hit = -1;
		scaled = int'(sample) * int'(SCALE);
		for (int i = 0; i < int'(tab_used); i++) begin
			if (hit < 0 && tab_addr[i] == addr)
				hit = i;
		end
		if (hit < 0) begin
			if (tab_used >= TABLE_DEPTH) begin
				u.status = ST_DROPPED;
			end else begin
				s = tab_used;
				tab_addr[s] = addr;
				tab_sig[s]  = SIG_W'(scaled);
				tab_md[s]   = md;
				tab_cnt[s]  = CNT_W'(1);
				tab_elig[s] = 1'b0;
				tab_used    = s + 1;
				u.status    = ST_ADDED;
				u.slot      = SLOT_OUT_W'(s);
			end
		end else begin
			s = hit;
			prev = tab_sig[s];
			cnt = tab_cnt[s];
			// summing phase, then blending of the average
			if (cnt < FULL_COUNT)
				sig = prev + scaled;
			else
				sig = (BLEND_KEEP * prev + BLEND_NEW * scaled) / BLEND_TOTAL;
			if (cnt < COUNT_MAX)
				cnt++;
			if (cnt == FULL_COUNT)
				sig = sig / FULL_COUNT;
			tab_sig[s]  = SIG_W'(sig);
			tab_cnt[s]  = CNT_W'(cnt);
			tab_md[s]   = md;
			tab_elig[s] = md && (cnt > FULL_COUNT);
			u.status    = ST_UPDATED;
			u.slot      = SLOT_OUT_W'(s);
		end
		// lowest eligible average under the ceiling, first slot on a tie
		best_sig = SIG_CEIL;
		best = -1;
		for (int i = 0; i < int'(tab_used); i++) begin
			if (tab_elig[i] && tab_sig[i] < best_sig) begin
				best_sig = tab_sig[i];
				best = i;
			end
		end
		if (best >= 0) begin
			u.found      = 1'b1;
			u.rider_slot = SLOT_OUT_W'(best);
			u.rider_addr = tab_addr[best];
		end
		return u;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_update_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
				tab_addr[i] = '0;
				tab_sig[i]  = '0;
				tab_cnt[i]  = '0;
				tab_md[i]   = 1'b0;
				tab_elig[i] = 1'b0;
			end
			tab_used = 0;
			bad_words = 0;
			pending_updates.delete();
		end else begin
			if (result.valid && result.ready) begin
				got.status     = result.update_status;
				got.slot       = result.entry_slot;
				got.found      = result.rider_found;
				got.rider_slot = result.rider_slot;
				got.rider_addr = result.rider_address;
				if (pending_updates.size() == 0) begin
					if (bad_words < REPORT_LIMIT)
						$display("%0t: result word with no beacon pending: status %0d slot %0d",
							$time, got.status, got.slot);
					bad_words++;
				end else begin
					want = pending_updates.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.found !== want.found || got.rider_slot !== want.rider_slot ||
							got.rider_addr !== want.rider_addr) begin
						if (bad_words < REPORT_LIMIT)
							$display({"%0t: update mismatch: expected status %0d slot %0d ",
								"rider %b/%0d/%h, got status %0d slot %0d rider %b/%0d/%h"},
								$time, want.status, want.slot, want.found, want.rider_slot,
								want.rider_addr, got.status, got.slot, got.found,
								got.rider_slot, got.rider_addr);
						bad_words++;
					end
				end
			end
			if (beacon.valid && beacon.ready)
				pending_updates.push_back(predict_update(beacon.ap_address,
					beacon.signal_sample, beacon.more_data));
		end
		words_pending = pending_updates.size();
	end

endmodule

/* bench/beacon_signal_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_signal_table_tb
// drives beacons into the signal table with random gaps and back-pressure;
// a directed fill of the table comes first, then phases of repeated beacons
// from the sixteen known senders mixed with stray senders that get dropped
// ----------------------------------------------------------------------------
module beacon_signal_table_tb;
	import bst_pkg::*;

	localparam int unsigned DEPTH           = DEF_TABLE_DEPTH;
	localparam int unsigned PHASES          = 10;
	localparam int unsigned PHASE_WORDS     = 108;
	localparam int unsigned IDLE_PCT        = 18;
	localparam int unsigned NOISE_PCT       = 15;
	localparam int unsigned HOLD_OFF_CYCLES = 500;
	// two beacons' worth of ring turns and arithmetic, with margin
	localparam int unsigned DRAIN_CYCLES    = 2 * (2 * DEPTH + 4) + 20;

	logic clk;
	logic arst_n;

	// calm: no idling on either side; hold_req: receiver holds off once
	bit calm;
	bit hold_req;

	int unsigned bad_words;
	int unsigned words_pending;

	// senders that end up owning the sixteen table slots, in slot order
	logic [ADDR_W-1:0] known_addr [DEPTH];

	bst_in_if  beacon_ch ();
	bst_out_if result_ch ();

	beacon_signal_table #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.beacon(beacon_ch),
		.result(result_ch)
	);

	beacon_signal_table_check #(
		.TABLE_DEPTH(DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.beacon       (beacon_ch),
		.result       (result_ch),
		.bad_words    (bad_words),
		.words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, or a long hold-off when asked for
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				// counted here so the sender keeps pushing and the block backs up
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// offers one beacon word and returns at the edge that takes it
	task automatic send_beacon(input logic [ADDR_W-1:0] addr,
			input logic [SAMPLE_W-1:0] sample, input logic md);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			beacon_ch.valid <= 1'b0;
			@(negedge clk);
		end
		beacon_ch.valid         <= 1'b1;
		beacon_ch.ap_address    <= addr;
		beacon_ch.signal_sample <= sample;
		beacon_ch.more_data     <= md;
		do @(posedge clk); while (!beacon_ch.ready);
	endtask

	task automatic stop_beacons();
		@(negedge clk);
		beacon_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (words_pending != 0) @(negedge clk);
	endtask

	// one phase: each known sender gets a signal level for the whole phase so
	// that averages settle, ties form and the ceiling is hit exactly
	task automatic send_phase();
		logic [SAMPLE_W-1:0] level [DEPTH];
		int unsigned jitter, md_pct, k;
		int d;
		for (int i = 0; i < int'(DEPTH); i++) begin
			case ($urandom_range(0, 6))
				0: level[i] = 8'd0;
				1: level[i] = 8'd99;
				2: level[i] = 8'd100;       // average lands on the ceiling itself
				3: level[i] = 8'd101;
				4: level[i] = 8'd255;
				5: level[i] = 8'd50;        // shared level, so ties between slots
				default: level[i] = SAMPLE_W'($urandom_range(0, 255));
			endcase
		end
		jitter = $urandom_range(0, 2);
		case ($urandom_range(0, 2))
			0: md_pct = 90;
			1: md_pct = 50;
			default: md_pct = 10;
		endcase
		repeat (PHASE_WORDS) begin
			if ($urandom_range(0, 99) < NOISE_PCT) begin
				// stray sender: dropped once the table is full
				send_beacon(ADDR_W'({$urandom, $urandom}), SAMPLE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else begin
				k = $urandom_range(0, DEPTH - 1);
				case (jitter)
					0: d = int'(level[k]);
					1: d = int'(level[k]) + int'($urandom_range(0, 6)) - 3;
					default: d = int'($urandom_range(0, 255));
				endcase
				if (d < 0)
					d = 0;
				if (d > 255)
					d = 255;
				send_beacon(known_addr[k], SAMPLE_W'(d), $urandom_range(0, 99) < md_pct);
			end
		end
	endtask

	initial begin
		bit fresh;
		int unsigned p;

		beacon_ch.valid         = 1'b0;
		beacon_ch.ap_address    = '0;
		beacon_ch.signal_sample = '0;
		beacon_ch.more_data     = 1'b0;
		calm     = 1'b1;
		hold_req = 1'b0;
		arst_n   = 1'b0;

		// address extremes and checkerboards first, the rest random and distinct
		known_addr[0] = '0;
		known_addr[1] = '1;
		known_addr[2] = {(ADDR_W / 2){2'b01}};
		known_addr[3] = {(ADDR_W / 2){2'b10}};
		for (int k = 4; k < int'(DEPTH); k++) begin
			do begin
				known_addr[k] = ADDR_W'({$urandom, $urandom});
				fresh = 1'b1;
				for (int j = 0; j < k; j++)
					if (known_addr[j] == known_addr[k])
						fresh = 1'b0;
			end while (!fresh);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: new entries at the sample extremes, an early update, then fill
		// the table, knock on it with two unknown senders and update two entries
		send_beacon(known_addr[0], 8'd0, 1'b1);
		send_beacon(known_addr[1], 8'd255, 1'b0);
		send_beacon(known_addr[0], 8'd255, 1'b1);
		for (int k = 2; k < int'(DEPTH); k++) begin
			send_beacon(known_addr[k],
				(k == 2) ? 8'd100 : (k == 3) ? 8'd99 : SAMPLE_W'($urandom_range(0, 255)),
				1'(k));
		end
		send_beacon(48'h0000_0000_0001, 8'd128, 1'b1);
		send_beacon(48'hFFFF_FFFF_FFFE, 8'd1, 1'b0);
		send_beacon(known_addr[DEPTH-1], 8'd0, 1'b1);
		send_beacon(known_addr[1], 8'd0, 1'b1);

		// sender pause until every word is back
		stop_beacons();
		wait_drained();
		@(posedge clk);

		// phase 0 runs with no idling at all; phase 3 starts from a drained
		// block with the receiver held off so the input side backs up
		for (p = 0; p < PHASES; p++) begin
			calm = (p == 0);
			if (p == 3)
				hold_req = 1'b1;
			send_phase();
			if (p == 2 || p == 6) begin
				stop_beacons();
				wait_drained();
				@(posedge clk);
			end
		end

		stop_beacons();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (bad_words == 0 && words_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bst_pkg.sv
rtl/bst_in_if.sv
rtl/bst_out_if.sv
rtl/bst_cell.sv
rtl/bst_update.sv
rtl/beacon_signal_table.sv
rtl/bst_checker.sv
bench/beacon_signal_table_check.sv
bench/beacon_signal_table_tb.sv
